[rtl/key_record_to_udp_header_macros.svh]
// ----------------------------------------------------------------------------
// key_record_to_udp_header_macros.svh
// Assertion macros used by the record deframer top module
// ----------------------------------------------------------------------------
`ifndef KEY_RECORD_TO_UDP_HEADER_MACROS_SVH
`define KEY_RECORD_TO_UDP_HEADER_MACROS_SVH

`ifndef SYNTH

// implication checked on every clock edge outside reset
`define KRUDP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("krudp assertion failed");

// condition that must never hold outside reset
`define KRUDP_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("krudp forbidden condition seen");

`else

`define KRUDP_ASSERT(lbl, prop)
`define KRUDP_NEVER(lbl, cond)

`endif

`endif

[rtl/krudp_pkg.sv]
// ----------------------------------------------------------------------------
// krudp_pkg
// Types and constants of the key record deframer
// ----------------------------------------------------------------------------
`default_nettype none

package krudp_pkg;

	// default geometry of a key record
	localparam int RECORD_BYTES_DEF = 256;
	localparam int RANDOM_BYTES_DEF = 32;

	// header sizes
	localparam int IP_HDR_BYTES  = 20;
	localparam int UDP_HDR_BYTES = 8;
	localparam int CAPTURE_BYTES = 12;

	// fixed ipv4 header words: version/ihl/tos and ttl/protocol
	localparam logic [15:0] IP_WORD_VER_TOS   = 16'h45ff;
	localparam logic [15:0] IP_WORD_TTL_PROTO = 16'hff11;

	// item kinds
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [7:0]  record_position;
		logic        record_end;
		logic [31:0] source_address;
		logic [31:0] destination_address;
		logic [15:0] source_port;
		logic [15:0] destination_port;
		logic [15:0] header_checksum;
		logic        layout_error;
	} out_word_t;

endpackage

`default_nettype wire

[rtl/krudp_track.sv]
// ----------------------------------------------------------------------------
// krudp_track
// Record position counter, info length register and header field capture
// ----------------------------------------------------------------------------
`default_nettype none

module krudp_track #(
	parameter int RECORD_BYTES = krudp_pkg::RECORD_BYTES_DEF,
	parameter int RANDOM_BYTES = krudp_pkg::RANDOM_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire krudp_pkg::in_word_t  word,
	output krudp_pkg::out_word_t      res
);

	localparam int PW = $clog2(RECORD_BYTES);
	localparam int BW = 18;
	localparam logic [BW-1:0] LEN_HI_POS  = BW'(RANDOM_BYTES + 4);
	localparam logic [BW-1:0] LEN_LO_POS  = BW'(RANDOM_BYTES + 5);
	localparam logic [BW-1:0] BASE_OFS    = BW'(RANDOM_BYTES + 6);
	localparam logic [BW-1:0] CAP_LEN     = BW'(krudp_pkg::CAPTURE_BYTES);
	localparam logic [BW-1:0] REC_LEN     = BW'(RECORD_BYTES);
	localparam logic [PW-1:0] LAST_POS    = PW'(RECORD_BYTES - 1);

	logic [PW-1:0] byte_count_q;
	logic [15:0]   info_len_q;
	logic [31:0]   src_addr_q;
	logic [31:0]   dst_addr_q;
	logic [15:0]   src_port_q;
	logic [15:0]   dst_port_q;

	logic          first;
	logic          last;
	logic          bad;
	logic          in_cap;
	logic [BW-1:0] pos_w;
	logic [BW-1:0] base;
	logic [BW-1:0] ofs;
	logic [7:0]    b;
	logic [15:0]   len_nxt;
	logic [31:0]   src_addr_nxt;
	logic [31:0]   dst_addr_nxt;
	logic [15:0]   src_port_nxt;
	logic [15:0]   dst_port_nxt;

	assign b     = word.data_byte;
	assign first = (byte_count_q == '0);
	assign last  = (byte_count_q == LAST_POS);
	assign pos_w = BW'(byte_count_q);

	// info length bytes, cleared at record start
	always_comb begin
		len_nxt = first ? 16'h0000 : info_len_q;
		if (pos_w == LEN_HI_POS) begin
			len_nxt = {b, len_nxt[7:0]};
		end else if (pos_w == LEN_LO_POS) begin
			len_nxt = {len_nxt[15:8], b};
		end
	end

	// capture window placement
	assign base   = BASE_OFS + {1'b0, len_nxt, 1'b0};
	assign in_cap = (pos_w >= base) && (pos_w < base + CAP_LEN);
	assign ofs    = pos_w - base;
	assign bad    = (base + CAP_LEN) > REC_LEN;

	// shift captured bytes into address and port fields
	always_comb begin
		src_addr_nxt = first ? 32'h0 : src_addr_q;
		dst_addr_nxt = first ? 32'h0 : dst_addr_q;
		src_port_nxt = first ? 16'h0 : src_port_q;
		dst_port_nxt = first ? 16'h0 : dst_port_q;
		if (in_cap) begin
			if (ofs[3:0] < 4'd4) begin
				src_addr_nxt = {src_addr_nxt[23:0], b};
			end else if (ofs[3:0] < 4'd8) begin
				dst_addr_nxt = {dst_addr_nxt[23:0], b};
			end else if (ofs[3:0] < 4'd10) begin
				src_port_nxt = {src_port_nxt[7:0], b};
			end else begin
				dst_port_nxt = {dst_port_nxt[7:0], b};
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			info_len_q   <= '0;
			src_addr_q   <= '0;
			dst_addr_q   <= '0;
			src_port_q   <= '0;
			dst_port_q   <= '0;
		end else if (step) begin
			if (word.kind == krudp_pkg::KIND_RESTART) begin
				byte_count_q <= '0;
				info_len_q   <= '0;
				src_addr_q   <= '0;
				dst_addr_q   <= '0;
				src_port_q   <= '0;
				dst_port_q   <= '0;
			end else begin
				byte_count_q <= last ? '0 : byte_count_q + PW'(1);
				info_len_q   <= len_nxt;
				src_addr_q   <= src_addr_nxt;
				dst_addr_q   <= dst_addr_nxt;
				src_port_q   <= src_port_nxt;
				dst_port_q   <= dst_port_nxt;
			end
		end
	end

	// result fields, header fields only on a clean record end
	always_comb begin
		res                     = '0;
		res.payload_byte        = b;
		res.record_position     = 8'(byte_count_q);
		res.record_end          = last;
		res.layout_error        = last && bad;
		if (last && !bad) begin
			res.source_address      = src_addr_nxt;
			res.destination_address = dst_addr_nxt;
			res.source_port         = src_port_nxt;
			res.destination_port    = dst_port_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/krudp_csum.sv]
// ----------------------------------------------------------------------------
// krudp_csum
// Ones complement checksum of the fixed ipv4 header
// ----------------------------------------------------------------------------
`default_nettype none

module krudp_csum #(
	parameter int RECORD_BYTES = krudp_pkg::RECORD_BYTES_DEF
) (
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	output logic      [15:0] csum
);

	localparam logic [15:0] TOTAL_LEN = 16'(krudp_pkg::IP_HDR_BYTES
		+ krudp_pkg::UDP_HDR_BYTES + RECORD_BYTES);
	localparam logic [18:0] FIXED_SUM = 19'(krudp_pkg::IP_WORD_VER_TOS)
		+ 19'(krudp_pkg::IP_WORD_TTL_PROTO) + 19'(TOTAL_LEN);

	logic [18:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	// sum of header words, then two end-around carry folds
	assign sum   = FIXED_SUM + 19'(src_addr[31:16]) + 19'(src_addr[15:0])
		+ 19'(dst_addr[31:16]) + 19'(dst_addr[15:0]);
	assign fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
	assign fold2 = fold1[15:0] + 16'(fold1[16]);
	assign csum  = ~fold2;

endmodule

`default_nettype wire

[rtl/key_record_to_udp_header.sv]
// Key record deframer: takes one stream byte per cycle (item_data.kind data) while
// the result port is not stalled and returns one word per data byte, registered in
// the input register and then in the result register once that is free; a restart
// item clears the partial record and returns nothing. Throughput is one byte per
// clock while result_ready holds, set by the single input register and single result
// register around the position counter and capture logic. item_ready depends
// combinationally on result_ready when both registers are full.
// ----------------------------------------------------------------------------
// key_record_to_udp_header
// Fixed record deframer with ipv4/udp header field capture and checksum
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_record_to_udp_header_macros.svh"

module key_record_to_udp_header #(
	parameter int RECORD_BYTES = krudp_pkg::RECORD_BYTES_DEF,
	parameter int RANDOM_BYTES = krudp_pkg::RANDOM_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire krudp_pkg::in_word_t  item_data,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output krudp_pkg::out_word_t      result_data
);

	krudp_pkg::in_word_t  item_s1;
	logic                 item_valid_s1;
	krudp_pkg::out_word_t result_s2;
	logic                 result_valid_s2;
	krudp_pkg::out_word_t trk_res;
	krudp_pkg::out_word_t res_full;
	logic [15:0]          csum;
	logic                 is_restart;
	logic                 out_free;
	logic                 step;
	logic                 load;

	// handshake between the two register stages
	assign is_restart = (item_s1.kind == krudp_pkg::KIND_RESTART);
	assign out_free   = !result_valid_s2 || result_ready;
	assign step       = item_valid_s1 && (is_restart || out_free);
	assign load       = item_valid_s1 && !is_restart && out_free;
	assign item_ready = !item_valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (step) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item_data;
		end
	end

	krudp_track #(
		.RECORD_BYTES(RECORD_BYTES),
		.RANDOM_BYTES(RANDOM_BYTES)
	) u_track (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (step),
		.word  (item_s1),
		.res   (trk_res)
	);

	krudp_csum #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_csum (
		.src_addr(trk_res.source_address),
		.dst_addr(trk_res.destination_address),
		.csum    (csum)
	);

	// complete result word, checksum only on a clean record end
	always_comb begin
		res_full                 = trk_res;
		res_full.header_checksum = (trk_res.record_end && !trk_res.layout_error)
			? csum : 16'h0000;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (load) begin
			result_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= res_full;
		end
	end

	assign result_valid = result_valid_s2;
	assign result_data  = result_s2;

	// checks
	`KRUDP_ASSERT(a_restart_silent,
		(step && is_restart && !result_valid_s2) |=> !result_valid)
	`KRUDP_ASSERT(a_data_lands,
		(item_valid_s1 && !is_restart && out_free) |=> result_valid)
	`KRUDP_ASSERT(a_end_position,
		(result_valid && result_data.record_end)
			|-> (result_data.record_position == 8'(RECORD_BYTES - 1)))
	`KRUDP_NEVER(a_error_clean,
		result_valid && result_data.layout_error
			&& (!result_data.record_end || result_data.header_checksum != 16'h0000))

endmodule

`default_nettype wire
